@@ src/kwsm_pkg.sv @@
// Shared types and codes for the k-way sorted merge block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package kwsm_pkg;

  typedef logic [1:0]         status_t;
  typedef logic [2:0]         list_idx_t;
  typedef logic signed [31:0] data_t;

  localparam status_t STATUS_DONE  = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Which list the pointer and count arrays are looked up for.
  typedef enum logic [1:0] {
    SEL_ITEM,
    SEL_SCAN,
    SEL_BEST
  } sel_e;

  typedef struct packed {
    logic capture;     // Input transfer: latch the item and restart the scan.
    sel_e sel;         // List whose pointers and count are looked up.
    logic scan_issue;  // Read the head of the scanned list and advance the scan.
    logic finish;      // Commit the item and write its result when the slot is free.
  } cmd_t;

  typedef struct packed {
    logic scan_last;   // The scan counter points at the last list.
    logic out_free;    // The result register can take a new result this cycle.
  } sts_t;

endpackage

`default_nettype wire

@@ src/kwsm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module kwsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/kwsm_ctrl.sv @@
// Sequencing state machine of the k-way sorted merge block.
// Depends on kwsm_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module kwsm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          mode_i,
  output logic               in_stall_o,
  output kwsm_pkg::cmd_t     cmd_o,
  input  wire kwsm_pkg::sts_t sts_i
);
  import kwsm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d           = state_q;
    cmd_o.capture     = 1'b0;
    cmd_o.sel         = SEL_ITEM;
    cmd_o.scan_issue  = 1'b0;
    cmd_o.finish      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = (mode_i == MODE_POP) ? ST_SCAN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.sel    = SEL_ITEM;
        cmd_o.finish = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.sel        = SEL_SCAN;
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The head read for the last list is compared in this cycle.
        cmd_o.sel = SEL_BEST;
        state_d   = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.sel    = SEL_BEST;
        cmd_o.finish = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q != ST_IDLE)
    else $error("accepted item did not start processing");

  a_scan_runs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && !sts_i.scan_last |=> state_q == ST_SCAN)
    else $error("scan stopped before the last list");

  a_drain_to_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |=> state_q == ST_COMMIT)
    else $error("drain cycle not followed by commit");

  a_finish_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish && sts_i.out_free |=> state_q == ST_IDLE)
    else $error("finished item did not return to idle");

endmodule

`default_nettype wire

@@ src/kwsm_dp.sv @@
// Datapath of the k-way sorted merge block: list pointers and counts, the value
// store, the head compare and the result register. Depends on kwsm_pkg and kwsm_ram.
`default_nettype none

module kwsm_dp #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  mode_i,
  input  wire kwsm_pkg::list_idx_t   list_index_i,
  input  wire kwsm_pkg::data_t       value_i,
  input  wire kwsm_pkg::cmd_t        cmd_i,
  output kwsm_pkg::sts_t             sts_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output kwsm_pkg::status_t          status_o,
  output kwsm_pkg::data_t            merged_value_o,
  output kwsm_pkg::list_idx_t        source_list_o
);
  import kwsm_pkg::*;

  localparam int LW = $clog2(NUM_LISTS);
  localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(NUM_LISTS * LIST_DEPTH);

  typedef logic [LW-1:0] lsel_t;
  typedef logic [PW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [AW-1:0] addr_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PW'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic addr_t list_addr(input lsel_t l, input ptr_t p);
    return AW'(l) * AW'(LIST_DEPTH) + AW'(p);
  endfunction

  // Latched item.
  logic      mode_q;
  list_idx_t idx_q;
  data_t     value_q;

  // Per-list FIFO bookkeeping.
  ptr_t rptr_q [NUM_LISTS];
  ptr_t wptr_q [NUM_LISTS];
  cnt_t fill_q [NUM_LISTS];

  // Scan and running minimum.
  lsel_t scan_q;
  logic  pend_v_q;
  lsel_t pend_idx_q;
  logic  found_q;
  lsel_t best_q;
  data_t best_val_q;

  logic  out_valid_q;

  lsel_t sel;
  ptr_t  rd_ptr, wr_ptr;
  cnt_t  fill_sel;
  logic  load_bad;
  logic  load_ok;
  logic  pop_ok;
  logic  commit;
  logic  ram_we;
  addr_t ram_waddr, ram_raddr;
  logic [31:0] ram_rdata;
  logic  take_head;
  logic  no_entries;

  always_comb begin
    case (cmd_i.sel)
      SEL_ITEM: sel = LW'(idx_q);
      SEL_SCAN: sel = scan_q;
      SEL_BEST: sel = best_q;
      default:  sel = scan_q;
    endcase
  end

  assign rd_ptr   = rptr_q[sel];
  assign wr_ptr   = wptr_q[sel];
  assign fill_sel = fill_q[sel];

  assign load_bad = (32'(idx_q) >= NUM_LISTS) || (fill_sel >= CW'(LIST_DEPTH));
  assign commit   = cmd_i.finish && sts_o.out_free;
  assign load_ok  = commit && (mode_q == MODE_LOAD) && !load_bad;
  assign pop_ok   = commit && (mode_q == MODE_POP) && found_q;

  assign ram_we    = load_ok;
  assign ram_waddr = list_addr(sel, wr_ptr);
  assign ram_raddr = list_addr(sel, rd_ptr);

  kwsm_ram #(
    .WIDTH(32),
    .DEPTH(NUM_LISTS * LIST_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(value_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign sts_o.scan_last = (scan_q == LW'(NUM_LISTS - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Strictly smaller replaces, so an equal head keeps the lower list.
  assign take_head = pend_v_q && (!found_q || ($signed(ram_rdata) < best_val_q));

  always_comb begin
    no_entries = 1'b1;
    for (int i = 0; i < NUM_LISTS; i++) begin
      if (fill_q[i] != '0) begin
        no_entries = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= mode_i;
      idx_q   <= list_index_i;
      value_q <= value_i;
    end
    if (take_head) begin
      best_q     <= pend_idx_q;
      best_val_q <= $signed(ram_rdata);
    end
    if (cmd_i.scan_issue) begin
      pend_idx_q <= scan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        rptr_q[i] <= '0;
        wptr_q[i] <= '0;
        fill_q[i] <= '0;
      end
      scan_q   <= '0;
      pend_v_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_issue && !sts_o.scan_last) begin
          scan_q <= scan_q + 1'b1;
        end
        if (take_head) begin
          found_q <= 1'b1;
        end
      end
      pend_v_q <= cmd_i.scan_issue && (fill_sel != '0);
      if (load_ok) begin
        wptr_q[sel] <= ptr_inc(wr_ptr);
        fill_q[sel] <= fill_sel + 1'b1;
      end
      if (pop_ok) begin
        rptr_q[sel] <= ptr_inc(rd_ptr);
        fill_q[sel] <= fill_sel - 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      if (mode_q == MODE_LOAD) begin
        status_o       <= load_bad ? STATUS_FULL : STATUS_DONE;
        merged_value_o <= '0;
        source_list_o  <= '0;
      end else if (found_q) begin
        status_o       <= STATUS_DONE;
        merged_value_o <= best_val_q;
        source_list_o  <= 3'(best_q);
      end else begin
        status_o       <= STATUS_EMPTY;
        merged_value_o <= '0;
        source_list_o  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_result_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(commit))
    else $error("result appeared without a committed item");

  // The scan visits every list, so each count is checked once per pop.
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sel == SEL_SCAN |-> fill_sel <= CW'(LIST_DEPTH))
    else $error("list fill count above depth");

  a_empty_means_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && mode_q == MODE_POP && !found_q |-> no_entries)
    else $error("empty reported while a list holds values");

  a_found_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok |-> fill_sel != '0)
    else $error("pop from an empty list");

endmodule

`default_nettype wire

@@ src/k_way_sorted_merge.sv @@
// Top level of the k-way sorted merge block: NUM_LISTS FIFO lists in one store,
// popped smallest head first. Depends on kwsm_pkg, kwsm_ctrl, kwsm_dp, kwsm_ram.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    mode_i, list_index_i, value_i
//   out      output     out_valid_o / out_stall_i  status_o, merged_value_o, source_list_o
//
// A load's result is registered from the LOAD state after its transfer, a pop's after
// the scan that reads one list head per cycle from the single-read store, the compare
// in the DRAIN state and the commit. The next transfer can follow in the cycle after
// the commit.
// One item is in work at a time; the result register lets the next item be
// taken while an earlier result still waits.
// Reset empties every list at once; the store itself is not cleared.
// A stall on the output holds the result and delays the next commit only.
`default_nettype none

module k_way_sorted_merge #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                mode_i,
  input  wire kwsm_pkg::list_idx_t list_index_i,
  input  wire kwsm_pkg::data_t     value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output kwsm_pkg::status_t        status_o,
  output kwsm_pkg::data_t          merged_value_o,
  output kwsm_pkg::list_idx_t      source_list_o
);
  import kwsm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kwsm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .mode_i    (mode_i),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  kwsm_dp #(
    .NUM_LISTS (NUM_LISTS),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_i),
    .list_index_i  (list_index_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .merged_value_o(merged_value_o),
    .source_list_o (source_list_o)
  );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the k-way sorted merge block: loads sorted runs and pops them back.
// Keeps its own copy of the list state and checks every result against it.
// Depends on kwsm_pkg and k_way_sorted_merge.
`timescale 1ns / 1ps

module tb_top;
  import kwsm_pkg::*;

  localparam int NUM_LISTS    = 8;
  localparam int LIST_DEPTH   = 64;
  localparam int ITEM_TARGET  = 1770;
  localparam int CALM_ITEMS   = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef struct {
    logic      mode;
    list_idx_t idx;
    data_t     value;
    bit        hold;    // Present only after every awaited result has come back.
  } merge_op_t;

  typedef struct {
    status_t   status;
    data_t     value;
    list_idx_t src;
  } merge_res_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_mode = MODE_LOAD;
  list_idx_t in_list = '0;
  data_t     in_value = '0;
  logic      out_stall = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  status_t   status_o;
  data_t     merged_value_o;
  list_idx_t source_list_o;

  merge_op_t  load_pop_items[$];
  merge_res_t awaited_results[$];
  int         mismatches = 0;

  // Shadow copy of the list store, pointers and fill counts.
  data_t list_mem[NUM_LISTS][LIST_DEPTH];
  int    head_ptr[NUM_LISTS] = '{default: 0};
  int    tail_ptr[NUM_LISTS] = '{default: 0};
  int    held[NUM_LISTS]     = '{default: 0};

  int in_gap = 0;
  int in_idle_rate = 0;
  int stall_left = 0;
  int out_stall_rate = 0;

  k_way_sorted_merge #(
    .NUM_LISTS (NUM_LISTS),
    .LIST_DEPTH(LIST_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .mode_i        (in_mode),
    .list_index_i  (in_list),
    .value_i       (in_value),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .status_o      (status_o),
    .merged_value_o(merged_value_o),
    .source_list_o (source_list_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic merge_res_t predict_merge(input merge_op_t op);
    merge_res_t res;
    int best;
    res.status = STATUS_DONE;
    res.value  = '0;
    res.src    = '0;
    best = -1;
    if (op.mode == MODE_LOAD) begin
      if (op.idx >= NUM_LISTS || held[op.idx] >= LIST_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        list_mem[op.idx][tail_ptr[op.idx]] = op.value;
        tail_ptr[op.idx] = (tail_ptr[op.idx] + 1) % LIST_DEPTH;
        held[op.idx]++;
      end
    end else begin
      // Strict compare keeps the lowest list index on equal heads.
      for (int i = 0; i < NUM_LISTS; i++) begin
        if (held[i] != 0) begin
          if (best < 0) begin
            best = i;
          end else if (list_mem[i][head_ptr[i]] < list_mem[best][head_ptr[best]]) begin
            best = i;
          end
        end
      end
      if (best < 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.value = list_mem[best][head_ptr[best]];
        res.src   = list_idx_t'(best);
        head_ptr[best] = (head_ptr[best] + 1) % LIST_DEPTH;
        held[best]--;
      end
    end
    return res;
  endfunction

  function automatic data_t pick_value(input int flavor);
    case (flavor)
      0: return data_t'($urandom);
      1: return data_t'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 5))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return '0;
          3:       return '1;
          4:       return 32'sh8000_0001;
          default: return 32'sh7fff_fffe;
        endcase
      end
    endcase
  endfunction

  function automatic void queue_op(input logic mode, input list_idx_t idx, input data_t value,
                                   input bit hold);
    merge_op_t op;
    op.mode  = mode;
    op.idx   = idx;
    op.value = value;
    op.hold  = hold;
    load_pop_items.push_back(op);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // Input side: one item is held on the port until its transfer.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic next_valid;
    merge_op_t op;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall_o) begin
        op = load_pop_items.pop_front();
        awaited_results.push_back(predict_merge(op));
        next_valid = 1'b0;
      end
      if ($urandom_range(0, 49) == 0) begin
        in_idle_rate = 3 * $urandom_range(0, 2);
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (load_pop_items.size() != 0 &&
                     !(load_pop_items[0].hold && awaited_results.size() != 0)) begin
          if (load_pop_items.size() > CALM_ITEMS && $urandom_range(0, 15) < in_idle_rate) begin
            in_gap = $urandom_range(0, 8);
          end else begin
            next_valid = 1'b1;
            in_mode  <= load_pop_items[0].mode;
            in_list  <= load_pop_items[0].idx;
            in_value <= load_pop_items[0].value;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Output side: check each result transfer and stall in bursts.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    merge_res_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("result with none awaited: status %0d value %0d list %0d",
                                  status_o, merged_value_o, source_list_o));
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status) begin
            note_mismatch($sformatf("status expected %0d, got %0d", want.status, status_o));
          end
          if (merged_value_o !== want.value) begin
            note_mismatch($sformatf("merged_value expected %0d, got %0d",
                                    want.value, merged_value_o));
          end
          if (source_list_o !== want.src) begin
            note_mismatch($sformatf("source_list expected %0d, got %0d",
                                    want.src, source_list_o));
          end
        end
      end
      if ($urandom_range(0, 49) == 0) begin
        out_stall_rate = 3 * $urandom_range(0, 2);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (load_pop_items.size() > CALM_ITEMS &&
                   $urandom_range(0, 15) < out_stall_rate) begin
        stall_left = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    data_t runs[NUM_LISTS][$];
    int kind;
    int flavor;
    int total;
    int lst;
    int pops;
    bit hold_first;

    // Pop on empty lists, extreme values, and three equal heads on lists 1, 3 and 6.
    queue_op(MODE_POP, 3'd5, 32'sh1234_5678, 1'b0);
    queue_op(MODE_LOAD, 3'd0, 32'sh8000_0000, 1'b0);
    queue_op(MODE_LOAD, 3'd3, '0, 1'b0);
    queue_op(MODE_LOAD, 3'd1, '0, 1'b0);
    queue_op(MODE_LOAD, 3'd7, 32'sh7fff_ffff, 1'b0);
    queue_op(MODE_LOAD, 3'd5, '1, 1'b0);
    queue_op(MODE_LOAD, 3'd2, 32'sh5555_5555, 1'b0);
    queue_op(MODE_LOAD, 3'd4, 32'shaaaa_aaaa, 1'b0);
    queue_op(MODE_LOAD, 3'd6, '0, 1'b0);
    queue_op(MODE_POP, 3'd7, '1, 1'b1);
    repeat (8) begin
      queue_op(MODE_POP, list_idx_t'($urandom_range(0, 7)), data_t'($urandom), 1'b0);
    end

    while (load_pop_items.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 19);
      hold_first = ($urandom_range(0, 3) == 0);
      if (kind <= 14) begin
        // Sorted runs on a random set of lists, then enough pops to drain them.
        // The broken variant stops halfway and leaves data behind.
        flavor = $urandom_range(0, 2);
        total = 0;
        for (int l = 0; l < NUM_LISTS; l++) begin
          runs[l].delete();
          if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 12)) runs[l].push_back(pick_value(flavor));
            runs[l].sort();
            total += runs[l].size();
          end
        end
        for (int left = total; left > 0; left--) begin
          do lst = $urandom_range(0, NUM_LISTS - 1); while (runs[lst].size() == 0);
          queue_op(MODE_LOAD, list_idx_t'(lst), runs[lst].pop_front(), hold_first);
          hold_first = 1'b0;
        end
        pops = (kind >= 12) ? total / 2 : total + $urandom_range(0, 2);
        repeat (pops) begin
          queue_op(MODE_POP, list_idx_t'($urandom_range(0, 7)), data_t'($urandom), hold_first);
          hold_first = 1'b0;
        end
      end else if (kind <= 18) begin
        repeat ($urandom_range(5, 30)) begin
          queue_op(logic'($urandom_range(0, 1)), list_idx_t'($urandom_range(0, 7)),
                   pick_value($urandom_range(0, 2)), 1'b0);
        end
      end else begin
        // Overfill one list so that the last loads are dropped, then drain.
        lst = $urandom_range(0, NUM_LISTS - 1);
        repeat (LIST_DEPTH + $urandom_range(1, 3)) begin
          queue_op(MODE_LOAD, list_idx_t'(lst), pick_value($urandom_range(0, 2)), 1'b0);
        end
        repeat (LIST_DEPTH + 4) begin
          queue_op(MODE_POP, list_idx_t'($urandom_range(0, 7)), data_t'($urandom), 1'b0);
        end
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (load_pop_items.size() != 0 || in_valid) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
